// ===== rtl/double_ended_queue_core_assert.svh =====
// Assertion macros shared by the deque RTL.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Check that a property holds at every clock edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define DEQ_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
package deq_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int AW         = $clog2(DEPTH);
   localparam int CW         = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4
   } op_type;

   typedef logic [AW-1:0] idx_type;
   typedef logic [CW-1:0] cnt_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic               pop_hit;
      logic               overflow;
      logic [10:0]        count_now;
      logic               is_empty;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_type;

   function automatic idx_type idx_inc(input idx_type i);
      return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic idx_type idx_dec(input idx_type i);
      return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
   endfunction

   // Widen a stored word back to the 32-bit item width, keeping its sign.
   function automatic logic signed [31:0] widen(input logic signed [DATA_WIDTH-1:0] x);
      return 32'(x);
   endfunction

endpackage

// ===== rtl/deq_ram.sv =====
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Deque core: a ring of DEPTH signed words with head/tail indexes and an occupancy count.
// Each accepted item passes through the fetch state and then the output register.
// An output stall holds it in the fetch state; no new item is taken until it leaves.
// A pop that must refresh the cached front or back word reads the single-port ring.
// Reset (synchronous, active high) empties the queue; the ring contents are not cleared.
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Queue bookkeeping: front and back ring positions plus occupancy.
   idx_type front_ff, front_in;
   idx_type back_ff,  back_in;
   cnt_type count_ff, count_in;

   // Cached front and back words, so only the neighbour of a popped end needs a read.
   logic signed [31:0] front_word_ff, front_word_in;
   logic signed [31:0] back_word_ff,  back_word_in;

   // Result fields held between acceptance and the fetch cycle.
   logic signed [31:0] popped_ff, popped_in;
   logic               hit_ff, hit_in;
   logic               ovf_ff, ovf_in;
   logic               fix_front_ff, fix_front_in;
   logic               fix_back_ff,  fix_back_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                  req_take, finish;
   logic                  is_push_f, is_push_b, is_pop_f, is_pop_b;
   logic                  full, empty, do_push, do_pop;
   logic signed [31:0]    push_word;
   logic                  mem_en, mem_we, mem_re;
   idx_type               mem_addr;
   logic [DATA_WIDTH-1:0] mem_rdata;
   logic signed [31:0]    fetched_word;
   logic signed [31:0]    front_out, back_out;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   // Finish the item once the output register is free or being emptied.
   assign finish = (state_ff == ST_FETCH) && (!rsp_valid_ff || !rsp_stall);

   // Decode; unused opcodes fall through as no operation.
   always_comb begin
      is_push_f = 1'b0;
      is_push_b = 1'b0;
      is_pop_f  = 1'b0;
      is_pop_b  = 1'b0;
      unique case (req_data.opcode)
         OP_PUSH_FRONT: is_push_f = 1'b1;
         OP_PUSH_BACK:  is_push_b = 1'b1;
         OP_POP_FRONT:  is_pop_f  = 1'b1;
         OP_POP_BACK:   is_pop_b  = 1'b1;
         default: ;
      endcase
   end

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = (is_push_f || is_push_b) && !full;
   assign do_pop  = (is_pop_f || is_pop_b) && !empty;
   // Wrap the pushed value to the stored width, as it will read back later.
   assign push_word = widen(req_data.value[DATA_WIDTH-1:0]);

   // The new end word must come from the ring only when at least two items remain.
   assign mem_we = req_take && do_push;
   assign mem_re = req_take && do_pop && (count_ff > CW'(2));
   assign mem_en = mem_we || mem_re;

   always_comb begin
      priority if (is_push_f) begin
         mem_addr = idx_dec(front_ff);
      end else if (is_push_b) begin
         mem_addr = idx_inc(back_ff);
      end else if (is_pop_f) begin
         mem_addr = idx_inc(front_ff);
      end else begin
         mem_addr = idx_dec(back_ff);
      end
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (req_data.value[DATA_WIDTH-1:0]),
      .rdata (mem_rdata)
   );

   assign fetched_word = widen(mem_rdata);

   // Apply the operation to the pointers and caches at acceptance.
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      popped_in     = popped_ff;
      hit_in        = hit_ff;
      ovf_in        = ovf_ff;
      fix_front_in  = fix_front_ff;
      fix_back_in   = fix_back_ff;

      if (req_take) begin
         state_in     = ST_FETCH;
         popped_in    = -32'sd1;
         hit_in       = do_pop;
         ovf_in       = (is_push_f || is_push_b) && full;
         fix_front_in = 1'b0;
         fix_back_in  = 1'b0;

         if (do_push) begin
            count_in = count_ff + 1'b1;
            if (is_push_f) begin
               front_in      = idx_dec(front_ff);
               front_word_in = push_word;
               if (empty) begin
                  back_word_in = push_word;
               end
            end else begin
               back_in      = idx_inc(back_ff);
               back_word_in = push_word;
               if (empty) begin
                  front_word_in = push_word;
               end
            end
         end else if (do_pop) begin
            count_in = count_ff - 1'b1;
            if (is_pop_f) begin
               front_in  = idx_inc(front_ff);
               popped_in = front_word_ff;
               // With one item left the new front is the current back.
               if (count_ff == CW'(2)) begin
                  front_word_in = back_word_ff;
               end
               fix_front_in = mem_re;
            end else begin
               back_in   = idx_dec(back_ff);
               popped_in = back_word_ff;
               if (count_ff == CW'(2)) begin
                  back_word_in = front_word_ff;
               end
               fix_back_in = mem_re;
            end
         end
      end else if (finish) begin
         state_in     = ST_IDLE;
         // Fold the fetched word into the cache and drop the pending fetch.
         fix_front_in = 1'b0;
         fix_back_in  = 1'b0;
         if (fix_front_ff) begin
            front_word_in = fetched_word;
         end
         if (fix_back_ff) begin
            back_word_in = fetched_word;
         end
      end
   end

   // Assemble the result with the freshly fetched word substituted where needed.
   assign front_out = fix_front_ff ? fetched_word : front_word_ff;
   assign back_out  = fix_back_ff  ? fetched_word : back_word_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.popped_value = popped_ff;
         rsp_in.pop_hit      = hit_ff;
         rsp_in.overflow     = ovf_ff;
         rsp_in.count_now    = 11'(count_ff);
         rsp_in.is_empty     = (count_ff == '0);
         rsp_in.front_value  = (count_ff == '0) ? -32'sd1 : front_out;
         rsp_in.back_value   = (count_ff == '0) ? -32'sd1 : back_out;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         back_ff      <= AW'(DEPTH - 1);
         count_ff     <= '0;
         fix_front_ff <= 1'b0;
         fix_back_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         fix_front_ff <= fix_front_in;
         fix_back_ff  <= fix_back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold without reset.
   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      popped_ff     <= popped_in;
      hit_ff        <= hit_in;
      ovf_ff        <= ovf_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DEQ_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "occupancy exceeds ring depth")
   `DEQ_ASSERT(a_empty_ptrs, (count_ff == '0) |-> (back_ff == idx_dec(front_ff)),
               "empty queue with back not just behind front")
   `DEQ_ASSERT(a_accept_busy, req_take |=> (state_ff == ST_FETCH),
               "accepted item did not enter the fetch cycle")
   `DEQ_ASSERT(a_fix_busy, (fix_front_ff || fix_back_ff) |-> (state_ff == ST_FETCH),
               "pending ring fetch outside the fetch cycle")
   `DEQ_ASSERT_NEVER(a_one_fix, fix_front_ff && fix_back_ff, "both ends await one fetch")

endmodule
